>>> sv/utf8d_pkg.sv
package utf8d_pkg;

  // Widths of the item fields
  localparam int unsigned CP_W   = 21;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 3;

  // Longest sequence accepted after reset
  localparam logic [LEN_W-1:0] MAX_SEQ_RESET = 3'd4;

  // Sequence lengths implied by the lead byte
  localparam logic [LEN_W-1:0] SEQ_LEN_2 = 3'd2;
  localparam logic [LEN_W-1:0] SEQ_LEN_3 = 3'd3;
  localparam logic [LEN_W-1:0] SEQ_LEN_4 = 3'd4;

  // Decoder state carried from byte to byte
  typedef struct packed {
    logic [CP_W-1:0] partial_value;
    logic [1:0]      bytes_pending;
    logic            frame_failed;
  } dec_state_t;

  // One result item
  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            decode_error;
    logic            end_of_frame;
  } dec_result_t;

endpackage

>>> sv/utf8d_step.sv
module utf8d_step (
  input  utf8d_pkg::dec_state_t       state_i,
  input  logic [7:0]                  text_byte_i,
  input  logic                        frame_last_i,
  input  logic [2:0]                  max_len_i,
  output utf8d_pkg::dec_state_t       state_o,
  output logic                        emit_o,
  output utf8d_pkg::dec_result_t      result_o
);
  import utf8d_pkg::*;

  logic             err;
  logic             done;
  logic [CP_W-1:0]  cp;
  logic [LEN_W-1:0] need;
  logic [CP_W-1:0]  lead_val;
  logic [CP_W-1:0]  shifted;
  dec_state_t       nxt;

  // Decode one byte against the running state
  always_comb begin
    err      = 1'b0;
    done     = 1'b0;
    cp       = '0;
    need     = '0;
    lead_val = '0;
    nxt      = state_i;
    shifted  = {state_i.partial_value[CP_W-7:0], text_byte_i[5:0]};

    if (state_i.bytes_pending == 2'd0) begin
      // lead byte classification
      if (text_byte_i[7] == 1'b0) begin
        if (text_byte_i == '0) begin
          err = 1'b1;
        end else begin
          cp   = CP_W'(text_byte_i[6:0]);
          done = 1'b1;
        end
      end else if (text_byte_i[7:5] == 3'b110) begin
        need     = SEQ_LEN_2;
        lead_val = CP_W'(text_byte_i[4:0]);
      end else if (text_byte_i[7:4] == 4'b1110) begin
        need     = SEQ_LEN_3;
        lead_val = CP_W'(text_byte_i[3:0]);
      end else if (text_byte_i[7:3] == 5'b11110) begin
        need     = SEQ_LEN_4;
        lead_val = CP_W'(text_byte_i[2:0]);
      end else begin
        err = 1'b1;
      end
      if (need != '0) begin
        if (need > max_len_i) begin
          err = 1'b1;
        end else begin
          nxt.bytes_pending = 2'(need - 3'd1);
          nxt.partial_value = lead_val;
        end
      end
    end else begin
      // continuation byte expected
      if (text_byte_i[7:6] != 2'b10) begin
        err = 1'b1;
      end else begin
        nxt.partial_value = shifted;
        nxt.bytes_pending = state_i.bytes_pending - 2'd1;
        if (state_i.bytes_pending == 2'd1) begin
          cp   = shifted;
          done = 1'b1;
        end
      end
    end

    // frame ends mid-sequence
    if (!err && !done && frame_last_i) begin
      err = 1'b1;
    end

    emit_o   = 1'b0;
    result_o = '{code_point: '0, decode_error: 1'b1, end_of_frame: frame_last_i};
    state_o  = nxt;

    if (state_i.frame_failed) begin
      // swallow the rest of a failed frame
      emit_o  = frame_last_i;
      state_o = state_i;
      if (frame_last_i) begin
        state_o = '0;
      end
    end else if (err) begin
      emit_o                = 1'b1;
      state_o               = '0;
      state_o.frame_failed  = !frame_last_i;
    end else if (done) begin
      emit_o                = 1'b1;
      state_o               = '0;
      result_o.code_point   = cp;
      result_o.decode_error = 1'b0;
    end
  end

endmodule

>>> sv/utf8_code_point_decoder.sv
// Path: input register, combinational decode step, result register.
// Throughput: one byte per cycle unless out_ready stalls output; the decode step sets it.
// Bytes that neither complete a character nor raise an error produce no result; after
// an error only the frame's last byte does. Reset (rst_n low, synchronous) clears the
// valid flags and the decode state and sets the length limit to 4.
module utf8_code_point_decoder (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  in_text_byte,
  input  logic                        in_frame_last,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [20:0]                 out_code_point,
  output logic                        out_decode_error,
  output logic                        out_end_of_frame,
  input  logic                        cfg_wr_en,
  input  logic [2:0]                  cfg_wr_data
);
  import utf8d_pkg::*;

  logic [LEN_W-1:0]  max_len_r;
  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              s1_last_r;
  dec_state_t        state_r;
  dec_state_t        state_nxt;
  logic              out_valid_r;
  dec_result_t       result_r;
  dec_result_t       result_nxt;
  logic              emit;
  logic              out_free;
  logic              advance;

  // Length limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_SEQ_RESET;
    end else if (cfg_wr_en) begin
      max_len_r <= cfg_wr_data;
    end
  end

  // Handshake: the staged byte moves on whenever the result slot can take it
  assign out_free = !out_valid_r || out_ready;
  assign advance  = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte_r <= in_text_byte;
      s1_last_r <= in_frame_last;
    end
  end

  utf8d_step u_step (
    .state_i      (state_r),
    .text_byte_i  (s1_byte_r),
    .frame_last_i (s1_last_r),
    .max_len_i    (max_len_r),
    .state_o      (state_nxt),
    .emit_o       (emit),
    .result_o     (result_nxt)
  );

  // Decode state updates once per consumed byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= advance && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_code_point   = result_r.code_point;
  assign out_decode_error = result_r.decode_error;
  assign out_end_of_frame = result_r.end_of_frame;

endmodule

>>> tb/tb_utf8_code_point_decoder.sv
module tb_utf8_code_point_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import utf8d_pkg::*;

  // Directed rows either send one byte or rewrite the length limit
  typedef enum logic {ROW_BYTE, ROW_LIMIT} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    logic [LEN_W-1:0]  limit;
    logic [BYTE_W-1:0] text_byte;
    logic              frame_last;
    logic              pinned;      // result typed in below instead of predicted
    dec_result_t       result;
  } stim_row_t;

  localparam dec_result_t NO_RESULT = '0;
  localparam int RANDOM_PER_PHASE = 275;
  localparam int N_PHASES = 7;
  localparam int DIRECTED_ROWS = 27;

  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    // single bytes, lowest and highest
    {ROW_BYTE,  3'd0, 8'h41, 1'b0, 1'b1, 21'h000041, 1'b0, 1'b0},
    {ROW_BYTE,  3'd0, 8'h7F, 1'b1, 1'b1, 21'h00007F, 1'b0, 1'b1},
    {ROW_BYTE,  3'd0, 8'h01, 1'b0, 1'b1, 21'h000001, 1'b0, 1'b0},
    // two and three byte characters
    {ROW_BYTE,  3'd0, 8'hC2, 1'b0, 1'b0, NO_RESULT},
    {ROW_BYTE,  3'd0, 8'hA9, 1'b1, 1'b0, NO_RESULT},
    {ROW_BYTE,  3'd0, 8'hE2, 1'b0, 1'b0, NO_RESULT},
    {ROW_BYTE,  3'd0, 8'h82, 1'b0, 1'b0, NO_RESULT},
    {ROW_BYTE,  3'd0, 8'hAC, 1'b0, 1'b0, NO_RESULT},
    // four bytes, all value bits set
    {ROW_BYTE,  3'd0, 8'hF7, 1'b0, 1'b0, NO_RESULT},
    {ROW_BYTE,  3'd0, 8'hBF, 1'b0, 1'b0, NO_RESULT},
    {ROW_BYTE,  3'd0, 8'hBF, 1'b0, 1'b0, NO_RESULT},
    {ROW_BYTE,  3'd0, 8'hBF, 1'b1, 1'b1, 21'h1FFFFF, 1'b0, 1'b1},
    // zero byte, then the rest of the frame is swallowed
    {ROW_BYTE,  3'd0, 8'h00, 1'b0, 1'b1, 21'h000000, 1'b1, 1'b0},
    {ROW_BYTE,  3'd0, 8'h41, 1'b0, 1'b0, NO_RESULT},
    {ROW_BYTE,  3'd0, 8'hC2, 1'b1, 1'b1, 21'h000000, 1'b1, 1'b1},
    // stray continuation on the last byte: one error result only
    {ROW_BYTE,  3'd0, 8'h80, 1'b1, 1'b1, 21'h000000, 1'b1, 1'b1},
    // bad lead byte
    {ROW_BYTE,  3'd0, 8'hFF, 1'b0, 1'b1, 21'h000000, 1'b1, 1'b0},
    {ROW_BYTE,  3'd0, 8'h00, 1'b1, 1'b1, 21'h000000, 1'b1, 1'b1},
    // lead byte followed by a non-continuation
    {ROW_BYTE,  3'd0, 8'hE2, 1'b0, 1'b0, NO_RESULT},
    {ROW_BYTE,  3'd0, 8'h41, 1'b0, 1'b1, 21'h000000, 1'b1, 1'b0},
    {ROW_BYTE,  3'd0, 8'h80, 1'b1, 1'b1, 21'h000000, 1'b1, 1'b1},
    // frame ends mid-sequence
    {ROW_BYTE,  3'd0, 8'hF0, 1'b0, 1'b0, NO_RESULT},
    {ROW_BYTE,  3'd0, 8'h9F, 1'b1, 1'b1, 21'h000000, 1'b1, 1'b1},
    // sequence too long for the limit
    {ROW_LIMIT, 3'd1, 8'h00, 1'b0, 1'b0, NO_RESULT},
    {ROW_BYTE,  3'd0, 8'hC2, 1'b1, 1'b1, 21'h000000, 1'b1, 1'b1},
    {ROW_BYTE,  3'd0, 8'h41, 1'b1, 1'b1, 21'h000041, 1'b0, 1'b1},
    {ROW_LIMIT, 3'd4, 8'h00, 1'b0, 1'b0, NO_RESULT}
  };

  localparam logic [LEN_W-1:0] PHASE_LIMITS [N_PHASES] = '{
    3'd2, 3'd0, 3'd4, 3'd3, 3'd7, 3'd1, 3'd4
  };

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [BYTE_W-1:0] in_text_byte = '0;
  logic              in_frame_last = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [CP_W-1:0]   out_code_point;
  logic              out_decode_error;
  logic              out_end_of_frame;
  logic              cfg_wr_en = 1'b0;
  logic [LEN_W-1:0]  cfg_wr_data = '0;

  // typed-in expectation travelling with the byte
  logic              pin_valid = 1'b0;
  dec_result_t       pin_result = '0;

  logic              quiet = 1'b0;     // no idling on either side while set
  int                fail_count = 0;

  // decoder mirror
  logic [CP_W-1:0]   acc_value = '0;
  logic [1:0]        cont_left = '0;
  logic              frame_bad = 1'b0;
  logic [LEN_W-1:0]  seq_limit = MAX_SEQ_RESET;

  dec_result_t       awaited_codes [$];

  utf8_code_point_decoder uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_text_byte     (in_text_byte),
    .in_frame_last    (in_frame_last),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_code_point   (out_code_point),
    .out_decode_error (out_decode_error),
    .out_end_of_frame (out_end_of_frame),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Advance the mirror by one byte; returns 1 when the byte yields a result
  function automatic bit decode_byte(input logic [BYTE_W-1:0] b, input logic last,
                                     output dec_result_t res);
    logic [LEN_W-1:0] need;
    logic [CP_W-1:0]  lead_bits;
    bit               bad;
    bit               done;
    need = '0;
    lead_bits = '0;
    bad = 1'b0;
    done = 1'b0;
    res = '0;
    // swallowing the tail of a broken frame
    if (frame_bad) begin
      if (last) begin
        frame_bad = 1'b0;
        acc_value = '0;
        cont_left = '0;
        res.decode_error = 1'b1;
        res.end_of_frame = 1'b1;
        return 1'b1;
      end
      return 1'b0;
    end
    if (cont_left == 2'd0) begin
      if (b >= 8'h01 && b <= 8'h7F) begin
        res.code_point = CP_W'(b);
        done = 1'b1;
      end else if (b[7:5] == 3'b110) begin
        need = SEQ_LEN_2;
        lead_bits = CP_W'(b[4:0]);
      end else if (b[7:4] == 4'b1110) begin
        need = SEQ_LEN_3;
        lead_bits = CP_W'(b[3:0]);
      end else if (b[7:3] == 5'b11110) begin
        need = SEQ_LEN_4;
        lead_bits = CP_W'(b[2:0]);
      end else begin
        bad = 1'b1;
      end
      // limit 0 rejects like 1, 5..7 accept like 4
      if (need != '0) begin
        if (need > seq_limit) begin
          bad = 1'b1;
        end else begin
          cont_left = 2'(need - 1);
          acc_value = lead_bits;
        end
      end
    end else if (b[7:6] != 2'b10) begin
      bad = 1'b1;
    end else begin
      acc_value = {acc_value[CP_W-7:0], b[5:0]};
      cont_left = cont_left - 2'd1;
      if (cont_left == 2'd0) begin
        res.code_point = acc_value;
        done = 1'b1;
      end
    end
    if (!bad && !done && last) bad = 1'b1;
    if (bad) begin
      acc_value = '0;
      cont_left = '0;
      frame_bad = !last;
      res.code_point = '0;
      res.decode_error = 1'b1;
      res.end_of_frame = last;
      return 1'b1;
    end
    if (done) begin
      acc_value = '0;
      cont_left = '0;
      res.end_of_frame = last;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic report_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  // Predict at each input transfer, check at each output transfer
  always @(posedge clk) begin
    dec_result_t predicted;
    dec_result_t seen;
    dec_result_t want;
    bit          yields;
    if (rst_n && in_valid && in_ready) begin
      yields = decode_byte(in_text_byte, in_frame_last, predicted);
      if (pin_valid) awaited_codes.insert(awaited_codes.size(), pin_result);
      else if (yields) awaited_codes.insert(awaited_codes.size(), predicted);
    end
    if (rst_n && out_valid && out_ready) begin
      seen = {out_code_point, out_decode_error, out_end_of_frame};
      if (awaited_codes.size() == 0) begin
        report_failure($sformatf("unexpected result: cp=%06h err=%b eof=%b",
                                 seen.code_point, seen.decode_error, seen.end_of_frame));
      end else begin
        want = awaited_codes.pop_front();
        if (want !== seen)
          report_failure($sformatf(
            "mismatch: expected cp=%06h err=%b eof=%b, got cp=%06h err=%b eof=%b",
            want.code_point, want.decode_error, want.end_of_frame,
            seen.code_point, seen.decode_error, seen.end_of_frame));
      end
    end
  end

  // Result side back-pressure
  always @(posedge clk) out_ready <= quiet || ($urandom_range(0, 99) >= 9);

  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last,
                           input logic pinned, input dec_result_t res);
    while (!quiet && $urandom_range(0, 99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_text_byte  <= b;
    in_frame_last <= last;
    pin_valid     <= pinned;
    pin_result    <= res;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Limit changes only with the decoder drained; trailing bytes may still be in flight
  task automatic write_limit(input logic [LEN_W-1:0] value);
    in_valid <= 1'b0;
    while (awaited_codes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    seq_limit = value;
    cfg_wr_en <= 1'b0;
  endtask

  // One frame: mostly well-formed characters, some corrupted, some pure noise
  task automatic send_frame(input logic [LEN_W-1:0] limit, output int sent);
    logic [BYTE_W-1:0] frame_bytes [$];
    int                top;
    int                mode;
    int                len;
    int                pos;
    top = (limit == '0) ? 1 : ((limit > 3'd4) ? 4 : int'(limit));
    mode = $urandom_range(0, 99);
    if (mode < 10) begin
      repeat ($urandom_range(1, 8)) frame_bytes.insert(frame_bytes.size(), 8'($urandom));
    end else begin
      repeat ($urandom_range(1, 6)) begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : $urandom_range(1, top);
        case (len)
          1: frame_bytes.insert(frame_bytes.size(), 8'($urandom_range(1, 127)));
          2: frame_bytes.insert(frame_bytes.size(), {3'b110, 5'($urandom)});
          3: frame_bytes.insert(frame_bytes.size(), {4'b1110, 4'($urandom)});
          default: frame_bytes.insert(frame_bytes.size(), {5'b11110, 3'($urandom)});
        endcase
        repeat (len - 1) frame_bytes.insert(frame_bytes.size(), {2'b10, 6'($urandom)});
      end
      if (mode < 18) begin
        pos = $urandom_range(0, frame_bytes.size() - 1);
        frame_bytes[pos] = 8'($urandom);
      end else if (mode < 24 && frame_bytes.size() > 1) begin
        void'(frame_bytes.pop_back());
      end
    end
    foreach (frame_bytes[i])
      send_byte(frame_bytes[i], i == frame_bytes.size() - 1, 1'b0, NO_RESULT);
    sent = frame_bytes.size();
  endtask

  // Main sequence
  initial begin
    int sent;
    int phase_items;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == ROW_LIMIT)
        write_limit(DIRECTED[i].limit);
      else
        send_byte(DIRECTED[i].text_byte, DIRECTED[i].frame_last,
                  DIRECTED[i].pinned, DIRECTED[i].result);
    end

    for (int p = 0; p < N_PHASES; p++) begin
      write_limit(PHASE_LIMITS[p]);
      quiet <= (p == 3);
      phase_items = 0;
      while (phase_items < RANDOM_PER_PHASE) begin
        send_frame(PHASE_LIMITS[p], sent);
        phase_items += sent;
      end
    end

    // drain
    in_valid <= 1'b0;
    while (awaited_codes.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    if (fail_count == 0) begin
      $display("utf8_code_point_decoder regression: pass");
    end else begin
      $display("utf8_code_point_decoder regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #400000;
    $display("utf8_code_point_decoder regression: fail");
    $finish;
  end

endmodule
